// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the serial master core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define TWRTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TWRTC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TWRTC_ASSERT(label, clk, rst_n, prop, msg)
`define TWRTC_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/twrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// twrtc_pkg
// Types and constants of the three-wire serial master.
// ----------------------------------------------------------------------------
package twrtc_pkg;

    // Default number of bytes moved by a burst
    localparam int BURST_BYTES_DEF = 8;

    // Command flag bits
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] READ_FLAG  = 8'h81;

    // Reset value of the burst command register
    localparam logic [7:0] BURST_CMD_RESET = 8'hBE;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_SINGLE_WR = 2'd0,
        REQ_SINGLE_RD = 2'd1,
        REQ_BURST_WR  = 2'd2,
        REQ_BURST_RD  = 2'd3
    } req_kind_t;

    // Sequencer phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WLOW  = 7'b0000010,
        PH_WHIGH = 7'b0000100,
        PH_RLOW  = 7'b0001000,
        PH_RHIGH = 7'b0010000,
        PH_STOP  = 7'b0100000,
        PH_END   = 7'b1000000
    } phase_t;

    // One tick in
    typedef struct packed {
        logic        start_req;
        logic [1:0]  req_type;
        logic [7:0]  reg_addr;
        logic [63:0] write_data;
        logic        io_in;
    } twrtc_in_t;

    // One tick out
    typedef struct packed {
        logic        chip_enable;
        logic        serial_clock;
        logic        io_out;
        logic        io_drive;
        logic        busy_res;
        logic        done_res;
        logic [63:0] read_data;
    } twrtc_out_t;

endpackage

// ===== rtl/three_wire_rtc_serial_master.sv =====
// The sequencer advances on every accepted tick, and its result is registered.
// Throughput: one tick per cycle while the result register is not held full.
// Ticks are taken while the result register is empty or being drained.
// Reset (rst_n low, asynchronous) returns to idle with the pins released.
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire serial master: command byte then single or burst data bytes.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master #(
    parameter int BURST_BYTES = twrtc_pkg::BURST_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_data,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  twrtc_pkg::twrtc_in_t   req_item,
    output logic                   res_valid,
    input  logic                   res_stall,
    output twrtc_pkg::twrtc_out_t  res_item
);

    logic                  advance;
    logic                  out_full;
    twrtc_pkg::twrtc_out_t tick_result;

    // Accept a tick whenever the result register can take its result
    assign req_stall = out_full;
    assign advance   = req_valid && !out_full;

    twrtc_core #(
        .BURST_BYTES (BURST_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (req_item),
        .result    (tick_result)
    );

    twrtc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_item (tick_result),
        .full      (out_full),
        .stall     (res_stall),
        .valid     (res_valid),
        .item      (res_item)
    );

endmodule

// ===== rtl/twrtc_core.sv =====
// ----------------------------------------------------------------------------
// twrtc_core
// Sequencer state, command register and per-tick pin and result logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twrtc_core #(
    parameter int BURST_BYTES = twrtc_pkg::BURST_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_data,
    input  logic                   advance,
    input  twrtc_pkg::twrtc_in_t   item,
    output twrtc_pkg::twrtc_out_t  result
);

    // Burst length clamped into 1..8
    localparam int BurstN = (BURST_BYTES < 1) ? 1 : ((BURST_BYTES > 8) ? 8 : BURST_BYTES);

    twrtc_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [1:0]  op_kind_reg, op_kind_next;
    logic [63:0] data_buffer_reg, data_buffer_next;
    logic [7:0]  burst_cmd_reg;

    logic        is_read;
    logic [3:0]  byte_total;
    logic [7:0]  buf_byte;
    logic [2:0]  ins_pos;
    logic        byte_done;

    assign is_read    = op_kind_reg[0];
    assign byte_total = op_kind_reg[1] ? 4'(BurstN) : 4'd1;
    assign buf_byte   = data_buffer_reg[{byte_count_reg[2:0], 3'b000} +: 8];
    assign ins_pos    = 3'(byte_count_reg - 4'd1);
    assign byte_done  = (bit_count_reg == 3'd7);

    // Next state and pin levels for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        byte_count_next  = byte_count_reg;
        shift_byte_next  = shift_byte_reg;
        op_kind_next     = op_kind_reg;
        data_buffer_next = data_buffer_reg;

        result              = '0;
        result.io_out       = 1'b1;
        result.busy_res     = 1'b1;

        case (phase_reg)
            twrtc_pkg::PH_WLOW:
            begin
                result.chip_enable = 1'b1;
                result.io_drive    = 1'b1;
                result.io_out      = shift_byte_reg[0];
                phase_next         = twrtc_pkg::PH_WHIGH;
            end
            twrtc_pkg::PH_WHIGH, twrtc_pkg::PH_RHIGH:
            begin
                result.chip_enable  = 1'b1;
                result.serial_clock = 1'b1;
                if (phase_reg == twrtc_pkg::PH_WHIGH)
                begin
                    result.io_drive = 1'b1;
                    result.io_out   = shift_byte_reg[0];
                    shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                end
                bit_count_next = bit_count_reg + 3'd1;
                if (!byte_done)
                begin
                    phase_next = (phase_reg == twrtc_pkg::PH_WHIGH) ?
                                 twrtc_pkg::PH_WLOW : twrtc_pkg::PH_RLOW;
                end
                else if (byte_count_reg == 4'd0)
                begin
                    // command byte sent: load the first data byte
                    byte_count_next = 4'd1;
                    shift_byte_next = is_read ? 8'd0 : data_buffer_reg[7:0];
                    phase_next      = is_read ? twrtc_pkg::PH_RLOW : twrtc_pkg::PH_WLOW;
                end
                else
                begin
                    // store the byte just read into its lane
                    if (is_read)
                    begin
                        data_buffer_next[{ins_pos, 3'b000} +: 8] = shift_byte_reg;
                    end
                    if (byte_count_reg >= byte_total)
                    begin
                        phase_next = twrtc_pkg::PH_STOP;
                    end
                    else
                    begin
                        shift_byte_next = is_read ? 8'd0 : buf_byte;
                        phase_next      = is_read ? twrtc_pkg::PH_RLOW : twrtc_pkg::PH_WLOW;
                        byte_count_next = byte_count_reg + 4'd1;
                    end
                end
            end
            twrtc_pkg::PH_RLOW:
            begin
                result.chip_enable = 1'b1;
                shift_byte_next    = {item.io_in, shift_byte_reg[7:1]};
                phase_next         = twrtc_pkg::PH_RHIGH;
            end
            twrtc_pkg::PH_STOP:
            begin
                result.chip_enable  = 1'b1;
                result.serial_clock = 1'b1;
                phase_next          = twrtc_pkg::PH_END;
            end
            twrtc_pkg::PH_END:
            begin
                result.serial_clock = 1'b1;
                result.done_res     = 1'b1;
                result.read_data    = is_read ? data_buffer_reg : 64'd0;
                phase_next          = twrtc_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = twrtc_pkg::PH_IDLE;
                if (item.start_req)
                begin
                    op_kind_next     = item.req_type;
                    bit_count_next   = 3'd0;
                    byte_count_next  = 4'd0;
                    data_buffer_next = item.req_type[0] ? 64'd0 : item.write_data;
                    case (twrtc_pkg::req_kind_t'(item.req_type))
                        twrtc_pkg::REQ_SINGLE_WR:
                            shift_byte_next = item.reg_addr | twrtc_pkg::WRITE_FLAG;
                        twrtc_pkg::REQ_SINGLE_RD:
                            shift_byte_next = item.reg_addr | twrtc_pkg::READ_FLAG;
                        twrtc_pkg::REQ_BURST_WR:
                            shift_byte_next = burst_cmd_reg;
                        default:
                            shift_byte_next = burst_cmd_reg | twrtc_pkg::READ_FLAG;
                    endcase
                    result.chip_enable = 1'b1;
                    phase_next         = twrtc_pkg::PH_WLOW;
                end
                else
                begin
                    result.busy_res = 1'b0;
                end
            end
        endcase
    end

    // Advance control state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= twrtc_pkg::PH_IDLE;
            bit_count_reg  <= 3'd0;
            byte_count_reg <= 4'd0;
            op_kind_reg    <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            op_kind_reg    <= op_kind_next;
        end
    end

    // Hold shift and data payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shift_byte_reg  <= shift_byte_next;
            data_buffer_reg <= data_buffer_next;
        end
    end

    // Burst command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_cmd_reg <= twrtc_pkg::BURST_CMD_RESET;
        end
        else if (cfg_write)
        begin
            burst_cmd_reg <= cfg_data;
        end
    end

    `TWRTC_ASSERT(a_end_goes_idle, clk, rst_n, advance && phase_reg == twrtc_pkg::PH_END |=> phase_reg == twrtc_pkg::PH_IDLE, "end tick not followed by idle")
    `TWRTC_NEVER(a_byte_count_range, clk, rst_n, byte_count_reg > 4'(BurstN), "byte count beyond burst length")
    `TWRTC_NEVER(a_drive_without_ce, clk, rst_n, result.io_drive && !result.chip_enable, "data pin driven with chip enable low")
    `TWRTC_NEVER(a_rdata_without_done, clk, rst_n, result.read_data != 64'd0 && !result.done_res, "read data outside done tick")

endmodule

// ===== rtl/twrtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// twrtc_out_stage
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module twrtc_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  twrtc_pkg::twrtc_out_t  load_item,
    output logic                   full,
    input  logic                   stall,
    output logic                   valid,
    output twrtc_pkg::twrtc_out_t  item
);

    logic                  valid_reg;
    twrtc_pkg::twrtc_out_t item_reg;

    // Hold the valid flag until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign full  = valid_reg && stall;
    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-wire serial master. A directed table of
// transactions, then random well-formed transactions under several burst
// command settings. Every tick result is checked against a tick-level model
// of the sequencer or a directed expectation, with random gaps on the request
// side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

    localparam int RAW_BURST = twrtc_pkg::BURST_BYTES_DEF;
    localparam int N_BURST   = (RAW_BURST < 1) ? 1 : ((RAW_BURST > 8) ? 8 : RAW_BURST);
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_TICKS  = 140;
    localparam int RAND_PHASES  = 4;

    // Typed pin levels for ticks that need no model
    localparam twrtc_pkg::twrtc_out_t IDLE_PINS  =
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0};
    localparam twrtc_pkg::twrtc_out_t START_PINS =
        {1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 64'd0};

    typedef struct {
        bit                     start;
        twrtc_pkg::req_kind_t   kind;
        bit [7:0]               addr;
        bit [63:0]              wdata;
        bit [63:0]              io_pat;
        bit                     noise;
        bit                     chk;
        twrtc_pkg::twrtc_out_t  want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [7:0]             cfg_data = 8'd0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    twrtc_pkg::twrtc_in_t   req_item = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    twrtc_pkg::twrtc_out_t  res_item;

    // Sequencer model state
    twrtc_pkg::phase_t      pr_phase = twrtc_pkg::PH_IDLE;
    bit [2:0]               bit_cnt = '0;
    bit [3:0]               byte_cnt = '0;
    bit [7:0]               shreg = '0;
    twrtc_pkg::req_kind_t   op = twrtc_pkg::REQ_SINGLE_WR;
    bit [63:0]              dbuf = '0;
    bit [7:0]               burst_cmd = twrtc_pkg::BURST_CMD_RESET;

    twrtc_pkg::twrtc_out_t  pins_due[$];
    dir_row_t               dir_rows[$];
    int                     errors = 0;
    int                     ticks_sent = 0;
    int                     cycles = 0;
    int                     stall_left = 0;
    bit                     calm = 1'b0;

    three_wire_rtc_serial_master #(
        .BURST_BYTES (RAW_BURST)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #5 clk = ~clk;

    // Hold reset at the start, then release for good
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("three_wire_rtc_serial_master test failed");
            $finish;
        end
    end

    // Choose the next data byte or the stop phase once a byte is through
    task automatic next_byte();
        int  n;
        int  pos;
        bit  rd;
        n  = op[1] ? N_BURST : 1;
        rd = op[0];
        if (byte_cnt == 0)
        begin
            byte_cnt = 1;
            if (rd)
            begin
                shreg    = '0;
                pr_phase = twrtc_pkg::PH_RLOW;
            end
            else
            begin
                shreg    = dbuf[7:0];
                pr_phase = twrtc_pkg::PH_WLOW;
            end
        end
        else
        begin
            if (rd)
            begin
                pos = (int'(byte_cnt) - 1) & 7;
                dbuf[pos*8 +: 8] = shreg;
            end
            if (int'(byte_cnt) >= n)
                pr_phase = twrtc_pkg::PH_STOP;
            else
            begin
                if (rd)
                begin
                    shreg    = '0;
                    pr_phase = twrtc_pkg::PH_RLOW;
                end
                else
                begin
                    pos      = int'(byte_cnt) & 7;
                    shreg    = dbuf[pos*8 +: 8];
                    pr_phase = twrtc_pkg::PH_WLOW;
                end
                byte_cnt = byte_cnt + 1;
            end
        end
    endtask

    // Advance the sequencer by one tick and give its pin levels
    task automatic master_step(input twrtc_pkg::twrtc_in_t t,
                               output twrtc_pkg::twrtc_out_t o);
        o          = '0;
        o.io_out   = 1'b1;
        o.busy_res = 1'b1;
        case (pr_phase)
            twrtc_pkg::PH_WLOW:
            begin
                o.chip_enable = 1'b1;
                o.io_drive    = 1'b1;
                o.io_out      = shreg[0];
                pr_phase      = twrtc_pkg::PH_WHIGH;
            end
            twrtc_pkg::PH_WHIGH:
            begin
                o.chip_enable  = 1'b1;
                o.serial_clock = 1'b1;
                o.io_drive     = 1'b1;
                o.io_out       = shreg[0];
                shreg          = shreg >> 1;
                bit_cnt        = bit_cnt + 1;
                if (bit_cnt == 0)
                    next_byte();
                else
                    pr_phase = twrtc_pkg::PH_WLOW;
            end
            twrtc_pkg::PH_RLOW:
            begin
                o.chip_enable = 1'b1;
                shreg         = {t.io_in, shreg[7:1]};
                pr_phase      = twrtc_pkg::PH_RHIGH;
            end
            twrtc_pkg::PH_RHIGH:
            begin
                o.chip_enable  = 1'b1;
                o.serial_clock = 1'b1;
                bit_cnt        = bit_cnt + 1;
                if (bit_cnt == 0)
                    next_byte();
                else
                    pr_phase = twrtc_pkg::PH_RLOW;
            end
            twrtc_pkg::PH_STOP:
            begin
                o.chip_enable  = 1'b1;
                o.serial_clock = 1'b1;
                pr_phase       = twrtc_pkg::PH_END;
            end
            twrtc_pkg::PH_END:
            begin
                o.serial_clock = 1'b1;
                o.done_res     = 1'b1;
                if (op[0])
                    o.read_data = dbuf;
                pr_phase = twrtc_pkg::PH_IDLE;
            end
            default:
            begin
                pr_phase = twrtc_pkg::PH_IDLE;
                if (t.start_req)
                begin
                    op       = twrtc_pkg::req_kind_t'(t.req_type);
                    bit_cnt  = '0;
                    byte_cnt = '0;
                    dbuf     = t.req_type[0] ? 64'd0 : t.write_data;
                    case (op)
                        twrtc_pkg::REQ_SINGLE_WR: shreg = t.reg_addr | twrtc_pkg::WRITE_FLAG;
                        twrtc_pkg::REQ_SINGLE_RD: shreg = t.reg_addr | twrtc_pkg::READ_FLAG;
                        twrtc_pkg::REQ_BURST_WR:  shreg = burst_cmd;
                        default:                  shreg = burst_cmd | twrtc_pkg::READ_FLAG;
                    endcase
                    o.chip_enable = 1'b1;
                    pr_phase      = twrtc_pkg::PH_WLOW;
                end
                else
                    o.busy_res = 1'b0;
            end
        endcase
    endtask

    // Offer one tick after a random gap and queue its pin levels once taken
    task automatic send_tick(input twrtc_pkg::twrtc_in_t it, input bit chk,
                             input twrtc_pkg::twrtc_out_t want);
        int                     gap;
        twrtc_pkg::twrtc_out_t  p;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        master_step(it, p);
        pins_due.push_back(chk ? want : p);
        ticks_sent++;
    endtask

    // Run one request to completion; optionally toss requests in while busy
    task automatic run_xfer(input twrtc_pkg::req_kind_t kind, input bit [7:0] addr,
                            input bit [63:0] wdata, input bit [63:0] io_pat,
                            input bit rnd_io, input bit noise,
                            input bit chk, input twrtc_pkg::twrtc_out_t want);
        twrtc_pkg::twrtc_in_t  it;
        int                    rd_idx;
        rd_idx        = 0;
        it.start_req  = 1'b1;
        it.req_type   = kind;
        it.reg_addr   = addr;
        it.write_data = wdata;
        it.io_in      = rnd_io ? 1'($urandom_range(0, 1)) : io_pat[0];
        send_tick(it, chk, want);
        while (pr_phase != twrtc_pkg::PH_IDLE)
        begin
            if (noise)
            begin
                it.start_req  = 1'($urandom_range(0, 1));
                it.req_type   = 2'($urandom_range(0, 3));
                it.reg_addr   = 8'($urandom);
                it.write_data = {$urandom, $urandom};
            end
            else
                it.start_req = 1'b0;
            if (rnd_io)
                it.io_in = 1'($urandom_range(0, 1));
            else
                it.io_in = io_pat[rd_idx % 64];
            if (pr_phase == twrtc_pkg::PH_RLOW)
                rd_idx++;
            send_tick(it, 1'b0, '0);
        end
    endtask

    // Drop valid and wait until every queued result is back
    task automatic drain();
        req_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_row(input bit start, input twrtc_pkg::req_kind_t kind,
                           input bit [7:0] addr, input bit [63:0] wdata,
                           input bit [63:0] io_pat, input bit noise, input bit chk,
                           input twrtc_pkg::twrtc_out_t want);
        dir_row_t r;
        r.start  = start;
        r.kind   = kind;
        r.addr   = addr;
        r.wdata  = wdata;
        r.io_pat = io_pat;
        r.noise  = noise;
        r.chk    = chk;
        r.want   = want;
        dir_rows.push_back(r);
    endtask

    task automatic check_pins(input twrtc_pkg::twrtc_out_t w,
                              input twrtc_pkg::twrtc_out_t g);
        if (g.chip_enable !== w.chip_enable)
        begin
            $error("chip_enable: expected %0d, got %0d", w.chip_enable, g.chip_enable);
            errors++;
        end
        if (g.serial_clock !== w.serial_clock)
        begin
            $error("serial_clock: expected %0d, got %0d", w.serial_clock, g.serial_clock);
            errors++;
        end
        if (g.io_out !== w.io_out)
        begin
            $error("io_out: expected %0d, got %0d", w.io_out, g.io_out);
            errors++;
        end
        if (g.io_drive !== w.io_drive)
        begin
            $error("io_drive: expected %0d, got %0d", w.io_drive, g.io_drive);
            errors++;
        end
        if (g.busy_res !== w.busy_res)
        begin
            $error("busy_res: expected %0d, got %0d", w.busy_res, g.busy_res);
            errors++;
        end
        if (g.done_res !== w.done_res)
        begin
            $error("done_res: expected %0d, got %0d", w.done_res, g.done_res);
            errors++;
        end
        if (g.read_data !== w.read_data)
        begin
            $error("read_data: expected %h, got %h", w.read_data, g.read_data);
            errors++;
        end
    endtask

    // Draw a stall length for every result transfer
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            stall_left = calm ? 0 : $urandom_range(0, 13);
        else if (stall_left != 0)
            stall_left = stall_left - 1;
        res_stall <= (stall_left != 0);
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_mon
        twrtc_pkg::twrtc_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pins_due.size() == 0)
            begin
                $error("result with no tick outstanding");
                errors++;
            end
            else
            begin
                want = pins_due.pop_front();
                check_pins(want, res_item);
            end
        end
    end

    // Main sequence
    initial
    begin : stim
        twrtc_pkg::twrtc_in_t  it;
        bit [7:0]              cmd;
        int                    sel;
        int                    k;
        twrtc_pkg::req_kind_t  kind;

        // Idle ticks, all extremes of the request fields, and busy-time requests
        add_row(1'b0, twrtc_pkg::REQ_SINGLE_WR, 8'h00, 64'd0, 64'd0, 1'b0, 1'b1, IDLE_PINS);
        add_row(1'b0, twrtc_pkg::REQ_BURST_RD, 8'hFF, '1, '1, 1'b0, 1'b1, IDLE_PINS);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_WR, 8'h00, 64'd0, 64'd0, 1'b0, 1'b1, START_PINS);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_WR, 8'hFF, '1, '1, 1'b0, 1'b1, START_PINS);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_WR, 8'h5A, 64'h0000_0000_0000_00A5, 64'd0,
                1'b1, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_RD, 8'h00, '1, 64'd0, 1'b0, 1'b1, START_PINS);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_RD, 8'hFF, 64'd0, '1, 1'b0, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_RD, 8'h3C, 64'd0, 64'h0000_0000_0000_C3A5,
                1'b1, 1'b0, '0);
        add_row(1'b0, twrtc_pkg::REQ_SINGLE_RD, 8'h11, 64'd0, 64'd0, 1'b0, 1'b1, IDLE_PINS);
        add_row(1'b1, twrtc_pkg::REQ_BURST_WR, 8'h00, 64'h0123_4567_89AB_CDEF, 64'd0,
                1'b0, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_BURST_WR, 8'hFF, '1, '1, 1'b1, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_BURST_RD, 8'h00, '1, '1, 1'b0, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_BURST_RD, 8'hFF, 64'd0, 64'h5555_5555_5555_5555,
                1'b1, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_BURST_RD, 8'h80, 64'd0, 64'd0, 1'b0, 1'b0, '0);
        add_row(1'b1, twrtc_pkg::REQ_SINGLE_WR, 8'h7F, 64'hFFFF_FFFF_FFFF_FF00, 64'd0,
                1'b0, 1'b0, '0);

        while (!rst_n)
            @(posedge clk);

        // Walk the directed table at the reset burst command
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].start)
                run_xfer(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].wdata,
                         dir_rows[i].io_pat, 1'b0, dir_rows[i].noise,
                         dir_rows[i].chk, dir_rows[i].want);
            else
            begin
                it.start_req  = 1'b0;
                it.req_type   = dir_rows[i].kind;
                it.reg_addr   = dir_rows[i].addr;
                it.write_data = dir_rows[i].wdata;
                it.io_in      = dir_rows[i].io_pat[0];
                send_tick(it, dir_rows[i].chk, dir_rows[i].want);
            end
        end

        // Random transactions under extreme and random burst commands
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            case (p)
                0:       cmd = 8'h00;
                1:       cmd = 8'hFF;
                default: cmd = 8'($urandom);
            endcase
            cfg_write <= 1'b1;
            cfg_data  <= cmd;
            @(posedge clk);
            cfg_write <= 1'b0;
            burst_cmd = cmd;

            k = ticks_sent + PHASE_TICKS;
            while (ticks_sent < k)
            begin
                calm = ($urandom_range(0, 4) == 0);
                sel  = $urandom_range(0, 9);
                if (sel == 0)
                begin
                    // Idle ticks with junk in the request fields
                    repeat ($urandom_range(1, 3))
                    begin
                        it.start_req  = 1'b0;
                        it.req_type   = 2'($urandom_range(0, 3));
                        it.reg_addr   = 8'($urandom);
                        it.write_data = {$urandom, $urandom};
                        it.io_in      = 1'($urandom_range(0, 1));
                        send_tick(it, 1'b0, '0);
                    end
                end
                else
                begin
                    // Mostly single transfers, bursts now and then
                    if (sel < 7)
                        kind = $urandom_range(0, 1) ? twrtc_pkg::REQ_SINGLE_RD
                                                    : twrtc_pkg::REQ_SINGLE_WR;
                    else
                        kind = $urandom_range(0, 1) ? twrtc_pkg::REQ_BURST_RD
                                                    : twrtc_pkg::REQ_BURST_WR;
                    run_xfer(kind, 8'($urandom), {$urandom, $urandom}, 64'd0, 1'b1,
                             ($urandom_range(0, 3) == 0), 1'b0, '0);
                end
            end
            calm = 1'b0;
        end

        drain();
        if (errors == 0)
            $display("three_wire_rtc_serial_master test passed");
        else
            $display("three_wire_rtc_serial_master test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/twrtc_pkg.sv
rtl/twrtc_core.sv
rtl/twrtc_out_stage.sv
rtl/three_wire_rtc_serial_master.sv
tb/sv/tb.sv
